FILE: src/matmul_then_dft2d_defines.svh
`ifndef MATMUL_THEN_DFT2D_DEFINES_SVH
`define MATMUL_THEN_DFT2D_DEFINES_SVH
// Assertion helpers for the block.
`define MTD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MTD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: src/mtd_pkg.sv
`default_nettype none
package mtd_pkg;
	localparam int DIM_LOG2 = 4;
	localparam int DIM = 1 << DIM_LOG2;
	localparam int CELLS = DIM * DIM;
	localparam int AW = 2 * DIM_LOG2;
	localparam int PW = 20;
	localparam int XW = 43;
	localparam int TW = 17;

	localparam logic [1:0] ACT_WRITE_A = 2'd0;
	localparam logic [1:0] ACT_WRITE_B = 2'd1;
	localparam logic [1:0] ACT_COMPUTE = 2'd2;
	localparam logic [1:0] ACT_READ = 2'd3;

	localparam logic KIND_ACK = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic mm_run;
		logic dft_run;
		logic [AW-1:0] out_addr;
		logic [AW-1:0] in_addr;
		logic [DIM_LOG2-1:0] kk;
		logic first;
		logic last;
	} dp_cmd_t;

	function automatic logic signed [TW-1:0] quarter_sine(input logic [4:0] r);
		logic signed [TW-1:0] v;
		case (r)
			5'd0: v = 17'sd0;
			5'd1: v = 17'sd3212;
			5'd2: v = 17'sd6393;
			5'd3: v = 17'sd9512;
			5'd4: v = 17'sd12540;
			5'd5: v = 17'sd15447;
			5'd6: v = 17'sd18205;
			5'd7: v = 17'sd20788;
			5'd8: v = 17'sd23170;
			5'd9: v = 17'sd25330;
			5'd10: v = 17'sd27246;
			5'd11: v = 17'sd28899;
			5'd12: v = 17'sd30274;
			5'd13: v = 17'sd31357;
			5'd14: v = 17'sd32138;
			5'd15: v = 17'sd32610;
			default: v = 17'sd32768;
		endcase
		return v;
	endfunction

	// Sine of 2*pi*j/64 in Q1.15, saturated at +32767.
	function automatic logic signed [TW-1:0] sine64(input logic [5:0] j);
		logic [1:0] q;
		logic [3:0] r;
		logic signed [TW-1:0] v;
		q = j[5:4];
		r = j[3:0];
		v = q[0] ? quarter_sine(5'd16 - {1'b0, r}) : quarter_sine({1'b0, r});
		if (q[1]) v = -v;
		if (v > 17'sd32767) v = 17'sd32767;
		return v;
	endfunction
endpackage
`default_nettype wire

FILE: src/mtd_ram.sv
`default_nettype none
module mtd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input wire clk,
	input wire we,
	input wire [$clog2(DEPTH)-1:0] waddr,
	input wire [WIDTH-1:0] wdata,
	input wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: src/mtd_datapath.sv
`default_nettype none
module mtd_datapath import mtd_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire dp_cmd_t cmd,
	input wire [1:0] action,
	input wire [AW-1:0] host_addr,
	input wire host_we,
	input wire signed [7:0] value,
	input wire [AW-1:0] a_raddr,
	input wire [AW-1:0] b_raddr,
	output logic signed [XW-1:0] rd_real,
	output logic signed [XW-1:0] rd_imag
);
	logic [7:0] a_rd, b_rd;
	logic [PW-1:0] p_rd;
	logic [XW-1:0] re_rd, im_rd;

	// Pipeline: s1 = memory data valid, s2 = operands registered, s3 = accumulate.
	logic mm_s1, mm_s2, dft_s1, dft_s2;
	logic first_s1, first_s2, last_s1, last_s2, last_s3;
	logic [AW-1:0] oaddr_s1, oaddr_s2, oaddr_s3;
	logic [DIM_LOG2-1:0] idx_s1;
	logic signed [15:0] prod_s2;
	logic signed [15:0] prod_s3;
	logic signed [PW-1:0] p_s2;
	logic signed [TW-1:0] cos_s2, sin_s2;
	logic signed [PW+TW-1:0] pc_s3, ps_s3;
	logic mm_s3, dft_s3, first_s3;
	logic signed [PW-1:0] macc_q;
	logic signed [XW-1:0] re_q, im_q;
	logic signed [PW-1:0] macc_nxt;
	logic signed [XW-1:0] re_nxt, im_nxt;
	logic [5:0] j64;

	mtd_ram #(.WIDTH(8), .DEPTH(CELLS)) u_a (.clk, .we(host_we && action == ACT_WRITE_A),
		.waddr(host_addr), .wdata(value), .raddr(a_raddr), .rdata(a_rd));
	mtd_ram #(.WIDTH(8), .DEPTH(CELLS)) u_b (.clk, .we(host_we && action == ACT_WRITE_B),
		.waddr(host_addr), .wdata(value), .raddr(b_raddr), .rdata(b_rd));
	mtd_ram #(.WIDTH(PW), .DEPTH(CELLS)) u_p (.clk, .we(mm_s3 && last_s3),
		.waddr(oaddr_s3), .wdata(macc_nxt), .raddr(cmd.in_addr), .rdata(p_rd));
	mtd_ram #(.WIDTH(XW), .DEPTH(CELLS)) u_re (.clk, .we(dft_s3 && last_s3),
		.waddr(oaddr_s3), .wdata(re_nxt), .raddr(host_addr), .rdata(re_rd));
	mtd_ram #(.WIDTH(XW), .DEPTH(CELLS)) u_im (.clk, .we(dft_s3 && last_s3),
		.waddr(oaddr_s3), .wdata(im_nxt), .raddr(host_addr), .rdata(im_rd));

	assign rd_real = re_rd;
	assign rd_imag = im_rd;

	// Twiddle index (l*n + k*m) mod DIM with address {m,n}; l from out_addr low.
	always_comb begin
		logic [DIM_LOG2-1:0] idx;
		idx = DIM_LOG2'(cmd.out_addr[DIM_LOG2-1:0] * cmd.in_addr[DIM_LOG2-1:0]
			+ cmd.out_addr[AW-1:DIM_LOG2] * cmd.in_addr[AW-1:DIM_LOG2]);
		j64 = 6'(idx) << (6 - DIM_LOG2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_s1 <= 1'b0; mm_s2 <= 1'b0; mm_s3 <= 1'b0;
			dft_s1 <= 1'b0; dft_s2 <= 1'b0; dft_s3 <= 1'b0;
		end else begin
			mm_s1 <= cmd.mm_run; mm_s2 <= mm_s1; mm_s3 <= mm_s2;
			dft_s1 <= cmd.dft_run; dft_s2 <= dft_s1; dft_s3 <= dft_s2;
		end
	end

	// The product store data lands in s1 and is held in p_s2 to meet the twiddle.
	always_ff @(posedge clk) begin
		first_s1 <= cmd.first; first_s2 <= first_s1; first_s3 <= first_s2;
		last_s1 <= cmd.last; last_s2 <= last_s1; last_s3 <= last_s2;
		oaddr_s1 <= cmd.out_addr; oaddr_s2 <= oaddr_s1; oaddr_s3 <= oaddr_s2;
		idx_s1 <= j64[5 -: DIM_LOG2];
		prod_s2 <= 16'(signed'({{8{a_rd[7]}}, a_rd}) * signed'({{8{b_rd[7]}}, b_rd}));
		prod_s3 <= prod_s2;
		p_s2 <= signed'(p_rd);
		cos_s2 <= sine64(6'({idx_s1, {(6-DIM_LOG2){1'b0}}}) + 6'd16);
		sin_s2 <= sine64(6'({idx_s1, {(6-DIM_LOG2){1'b0}}}));
		pc_s3 <= p_s2 * cos_s2;
		ps_s3 <= p_s2 * sin_s2;
		if (mm_s3) macc_q <= macc_nxt;
		if (dft_s3) begin
			re_q <= re_nxt;
			im_q <= im_nxt;
		end
	end

	always_comb begin
		macc_nxt = (first_s3 ? '0 : macc_q) + PW'(prod_s3);
		re_nxt = (first_s3 ? '0 : re_q) + XW'(pc_s3);
		im_nxt = (first_s3 ? '0 : im_q) - XW'(ps_s3);
	end
endmodule
`default_nettype wire

FILE: src/mtd_ctrl.sv
`default_nettype none
module mtd_ctrl import mtd_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire [1:0] action,
	output logic busy,
	output dp_cmd_t cmd,
	output logic [AW-1:0] a_raddr,
	output logic [AW-1:0] b_raddr,
	output logic ack
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MM = 4'b0010,
		ST_DFT = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t state_q;
	logic [AW-1:0] out_q;
	logic [AW-1:0] in_q;
	logic [DIM_LOG2-1:0] k_q;
	logic [2:0] drain_q;
	logic next_dft_q;
	logic in_last, k_last;

	assign in_last = &in_q;
	assign k_last = &k_q;
	assign busy = state_q != ST_IDLE;

	// Matrix product: out_q = {i,j}, k_q walks the inner index.
	assign a_raddr = {out_q[AW-1:DIM_LOG2], k_q};
	assign b_raddr = {k_q, out_q[DIM_LOG2-1:0]};

	always_comb begin
		cmd = '0;
		cmd.out_addr = out_q;
		cmd.in_addr = in_q;
		cmd.kk = k_q;
		if (state_q == ST_MM) begin
			cmd.mm_run = 1'b1;
			cmd.first = k_q == '0;
			cmd.last = k_last;
		end
		if (state_q == ST_DFT) begin
			cmd.dft_run = 1'b1;
			cmd.first = in_q == '0;
			cmd.last = in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_q <= '0; in_q <= '0; k_q <= '0; drain_q <= '0;
			next_dft_q <= 1'b0; ack <= 1'b0;
		end else begin
			ack <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start && action == ACT_COMPUTE) begin
						state_q <= ST_MM;
						out_q <= '0; k_q <= '0;
					end
				end
				ST_MM: begin
					k_q <= k_q + 1'b1;
					if (k_last) begin
						out_q <= out_q + 1'b1;
						if (&out_q) begin
							state_q <= ST_DRAIN;
							drain_q <= '0;
							next_dft_q <= 1'b1;
						end
					end
				end
				ST_DFT: begin
					in_q <= in_q + 1'b1;
					if (in_last) begin
						out_q <= out_q + 1'b1;
						if (&out_q) begin
							state_q <= ST_DRAIN;
							drain_q <= '0;
							next_dft_q <= 1'b0;
						end
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 3'd4) begin
						if (next_dft_q) begin
							state_q <= ST_DFT;
							out_q <= '0; in_q <= '0;
						end else begin
							state_q <= ST_IDLE;
							ack <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: src/matmul_then_dft2d.sv
`default_nettype none
// Matrix multiply followed by a direct 2D DFT of the DIM x DIM product.
// Command channel: a transaction is taken when start is high and busy is low.
// action selects write A, write B, compute, or read an output entry at (row, col).
// Writes give no result. A read gives one result transaction, through the
// registered store read and the registered output, with kind = 1 and the stored
// real/imag coefficients. A compute runs the matrix product, drains the pipeline,
// then runs the DFT over the stored product and drains again; the product and the
// DFT share the pipeline stages but use separate multipliers and read ports.
// busy stays high while the compute runs, and the result (kind = 0, zero payload)
// comes on done the cycle after busy falls.
// Each result is shown on done for one cycle; the receiver cannot stall it.
// Reset clears the controller; the A, B and output stores hold no defined
// contents until written or computed.
`include "matmul_then_dft2d_defines.svh"
module matmul_then_dft2d import mtd_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire start,
	output logic busy,
	input wire [1:0] action,
	input wire [3:0] row,
	input wire [3:0] col,
	input wire signed [7:0] value,
	output logic done,
	output logic kind,
	output logic signed [XW-1:0] real_part,
	output logic signed [XW-1:0] imag_part
);
	dp_cmd_t cmd;
	logic ctrl_busy, ack;
	logic [AW-1:0] a_raddr, b_raddr, host_addr;
	logic signed [XW-1:0] rd_real, rd_imag;
	logic accept, rd_s1, rd_s2;

	assign busy = ctrl_busy;
	assign accept = start && !ctrl_busy;
	assign host_addr = {row[DIM_LOG2-1:0], col[DIM_LOG2-1:0]};

	mtd_ctrl u_ctrl (.clk, .arst_n, .start(accept), .action, .busy(ctrl_busy),
		.cmd, .a_raddr, .b_raddr, .ack);

	mtd_datapath u_dp (.clk, .arst_n, .cmd, .action, .host_addr,
		.host_we(accept), .value, .a_raddr, .b_raddr, .rd_real, .rd_imag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0; rd_s2 <= 1'b0;
		end else begin
			rd_s1 <= accept && action == ACT_READ;
			rd_s2 <= rd_s1;
		end
	end

	// The registered RAM read lands in the cycle after the command; done and the payload are registered from it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= rd_s1 || ack;
		end
	end
	always_ff @(posedge clk) begin
		kind <= rd_s1 ? KIND_READ : KIND_ACK;
		real_part <= rd_s1 ? rd_real : '0;
		imag_part <= rd_s1 ? rd_imag : '0;
	end

	`MTD_ASSERT_IMPL(a_ack_idle, ack, !busy)
	`MTD_ASSERT_IMPL(a_no_overlap, rd_s1, !ack)
	`MTD_ASSERT_NEXT(a_read_done, rd_s1, done && kind == KIND_READ)
endmodule
`default_nettype wire
